[design/dmbs_pkg.sv]
// Shared widths, types and constants for the depth-masked bilinear sampler.
package dmbs_pkg;

   localparam int FRAC_BITS      = 8;
   localparam int DEPTH_BITS     = 16;

   localparam int FRAC_W         = 8;
   localparam int INT_W          = 8;
   localparam int DEP_W          = 16;
   localparam int INT_OUT_W      = 12;
   localparam int DEP_OUT_W      = 16;
   localparam int INT_FRAC_SHIFT = 4;

   localparam int FU_W   = (FRAC_BITS < FRAC_W) ? FRAC_BITS : FRAC_W;
   localparam int DEPU_W = (DEPTH_BITS < DEP_W) ? DEPTH_BITS : DEP_W;

   localparam int AXW_W  = FRAC_BITS + 1;
   localparam int WGT_W  = 2 * FRAC_BITS + 1;
   localparam int PI_W   = WGT_W + INT_W;
   localparam int PZ_W   = WGT_W + DEPU_W;

   localparam int QI_W   = INT_W + INT_FRAC_SHIFT;
   localparam int QZ_W   = DEPU_W;
   localparam int NUMI_W = QI_W + 2 * FRAC_BITS;
   localparam int NUMZ_W = QZ_W + 2 * FRAC_BITS;

   localparam int DIV_STEPS = (QI_W > QZ_W) ? QI_W : QZ_W;
   localparam int NUM_W     = (NUMI_W > NUMZ_W) ? NUMI_W : NUMZ_W;

   localparam int LANES    = 2;
   localparam int LANE_INT = 0;
   localparam int LANE_DEP = 1;

   localparam int NEIGH = 4;

   localparam logic [AXW_W-1:0]     FRAC_ONE    = AXW_W'(1) << FRAC_BITS;
   localparam logic [INT_OUT_W-1:0] INT_OUT_MAX =
      INT_OUT_W'(((1 << INT_W) - 1) << INT_FRAC_SHIFT);

   typedef logic [WGT_W-1:0]     wgt_type;
   typedef logic [NUM_W-1:0]     num_type;
   typedef logic [DIV_STEPS-1:0] quo_type;

   typedef struct packed {
      logic valid;
      logic nz;
   } div_ctl_type;

endpackage

[design/dmbs_if.sv]
// Request and response channel interfaces of the bilinear sampler.
interface dmbs_req_if;
   import dmbs_pkg::*;

   logic              valid;
   logic              ready;
   logic [INT_W-1:0]  int_tl;
   logic [DEP_W-1:0]  dep_tl;
   logic [INT_W-1:0]  int_tr;
   logic [DEP_W-1:0]  dep_tr;
   logic [INT_W-1:0]  int_bl;
   logic [DEP_W-1:0]  dep_bl;
   logic [INT_W-1:0]  int_br;
   logic [DEP_W-1:0]  dep_br;
   logic [FRAC_W-1:0] frac_u;
   logic [FRAC_W-1:0] frac_v;

   modport source (
      output valid, int_tl, dep_tl, int_tr, dep_tr, int_bl, dep_bl,
             int_br, dep_br, frac_u, frac_v,
      input  ready
   );

   modport sink (
      input  valid, int_tl, dep_tl, int_tr, dep_tr, int_bl, dep_bl,
             int_br, dep_br, frac_u, frac_v,
      output ready
   );
endinterface

interface dmbs_rsp_if;
   import dmbs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [INT_OUT_W-1:0] int_out;
   logic [DEP_OUT_W-1:0] dep_out;
   logic                 valid_res;

   modport source (
      output valid, int_out, dep_out, valid_res,
      input  ready
   );

   modport sink (
      input  valid, int_out, dep_out, valid_res,
      output ready
   );
endinterface

[design/dmbs_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
module dmbs_div_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  dmbs_pkg::div_ctl_type in_ctl,
   input  dmbs_pkg::wgt_type     in_divisor,
   input  dmbs_pkg::num_type     in_num [dmbs_pkg::LANES],
   output dmbs_pkg::div_ctl_type out_ctl,
   output dmbs_pkg::quo_type     out_quo [dmbs_pkg::LANES]
);
   import dmbs_pkg::*;

   div_ctl_type ctl_ff  [DIV_STEPS];
   wgt_type     dvs_ff  [DIV_STEPS];
   wgt_type     rem_ff  [DIV_STEPS][LANES];
   quo_type     low_ff  [DIV_STEPS][LANES];

   div_ctl_type ctl_src [DIV_STEPS];
   wgt_type     dvs_src [DIV_STEPS];
   wgt_type     rem_src [DIV_STEPS][LANES];
   quo_type     low_src [DIV_STEPS][LANES];

   wgt_type     rem_in  [DIV_STEPS][LANES];
   quo_type     low_in  [DIV_STEPS][LANES];

   always_comb begin
      logic [NUM_W+WGT_W-1:0] top_bits;
      top_bits = '0;
      for (int s = 0; s < DIV_STEPS; s++) begin
         if (s == 0) begin
            ctl_src[s] = in_ctl;
            dvs_src[s] = in_divisor;
            for (int l = 0; l < LANES; l++) begin
               top_bits      = {{WGT_W{1'b0}}, in_num[l]} >> DIV_STEPS;
               rem_src[s][l] = top_bits[WGT_W-1:0];
               low_src[s][l] = in_num[l][DIV_STEPS-1:0];
            end
         end else begin
            ctl_src[s] = ctl_ff[s-1];
            dvs_src[s] = dvs_ff[s-1];
            for (int l = 0; l < LANES; l++) begin
               rem_src[s][l] = rem_ff[s-1][l];
               low_src[s][l] = low_ff[s-1][l];
            end
         end
      end
   end

   always_comb begin
      logic [WGT_W:0] trial;
      logic [WGT_W:0] diff;
      logic           ge;
      trial = '0;
      diff  = '0;
      ge    = 1'b0;
      for (int s = 0; s < DIV_STEPS; s++) begin
         for (int l = 0; l < LANES; l++) begin
            trial = {rem_src[s][l], low_src[s][l][DIV_STEPS-1]};
            diff  = trial - {1'b0, dvs_src[s]};
            ge    = (trial >= {1'b0, dvs_src[s]});
            rem_in[s][l] = ge ? diff[WGT_W-1:0] : trial[WGT_W-1:0];
            low_in[s][l] = {low_src[s][l][DIV_STEPS-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STEPS; s++) begin
            ctl_ff[s] <= '0;
         end
      end else if (advance) begin
         for (int s = 0; s < DIV_STEPS; s++) begin
            ctl_ff[s] <= ctl_src[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < DIV_STEPS; s++) begin
            dvs_ff[s] <= dvs_src[s];
            for (int l = 0; l < LANES; l++) begin
               rem_ff[s][l] <= rem_in[s][l];
               low_ff[s][l] <= low_in[s][l];
            end
         end
      end
   end

   assign out_ctl = ctl_ff[DIV_STEPS-1];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quo[l] = low_ff[DIV_STEPS-1][l];
      end
   end

endmodule

[design/depth_masked_bilinear_sample.sv]
// Top level of the depth-masked bilinear sampler.
//
//   channel   port      dir   beat
//   request   req_bus   in    four neighbours (intensity, depth) and u/v offsets
//   response  rsp_bus   out   interpolated intensity Q8.4, depth, valid flag
//
// One beat per cycle sustained while responses are taken; a beat passes the weight,
// product, sum and numerator stages and then the one-bit-per-stage divider.
// Synchronous active-high reset clears all stage valid bits.
// A stall at the response holds every stage together; req_bus.ready falls
// only while the last stage holds a beat that is not taken.
module depth_masked_bilinear_sample (
   input logic          clock,
   input logic          reset,
   dmbs_req_if.sink     req_bus,
   dmbs_rsp_if.source   rsp_bus
);
   import dmbs_pkg::*;

   logic advance;

   logic [INT_W-1:0]  int_src [NEIGH];
   logic [DEPU_W-1:0] dep_src [NEIGH];
   logic [AXW_W-1:0]  wu      [2];
   logic [AXW_W-1:0]  wv      [2];
   wgt_type           w1_in   [NEIGH];

   logic              v1_ff;
   wgt_type           w1_ff   [NEIGH];
   logic [INT_W-1:0]  i1_ff   [NEIGH];
   logic [DEPU_W-1:0] z1_ff   [NEIGH];

   logic              v2_ff;
   wgt_type           w2_ff   [NEIGH];
   logic [PI_W-1:0]   pi2_ff  [NEIGH];
   logic [PZ_W-1:0]   pz2_ff  [NEIGH];

   logic              v3_ff;
   wgt_type           sw3_ff;
   logic [PI_W-1:0]   si3_ff;
   logic [PZ_W-1:0]   sz3_ff;
   wgt_type           sw3_in;
   logic [PI_W-1:0]   si3_in;
   logic [PZ_W-1:0]   sz3_in;

   logic              v4_ff;
   logic              nz4_ff;
   wgt_type           dvs4_ff;
   num_type           num4_ff [LANES];
   wgt_type           half3;

   div_ctl_type       div_in_ctl;
   div_ctl_type       div_out_ctl;
   quo_type           div_quo [LANES];

   assign advance       = !div_out_ctl.valid || rsp_bus.ready;
   assign req_bus.ready = advance;

   always_comb begin
      logic [2*AXW_W-1:0] wprod;
      int_src[0] = req_bus.int_tl;
      int_src[1] = req_bus.int_tr;
      int_src[2] = req_bus.int_bl;
      int_src[3] = req_bus.int_br;
      dep_src[0] = req_bus.dep_tl[DEPU_W-1:0];
      dep_src[1] = req_bus.dep_tr[DEPU_W-1:0];
      dep_src[2] = req_bus.dep_bl[DEPU_W-1:0];
      dep_src[3] = req_bus.dep_br[DEPU_W-1:0];
      wu[1] = AXW_W'(req_bus.frac_u[FU_W-1:0]);
      wv[1] = AXW_W'(req_bus.frac_v[FU_W-1:0]);
      wu[0] = FRAC_ONE - wu[1];
      wv[0] = FRAC_ONE - wv[1];
      wprod = '0;
      for (int k = 0; k < NEIGH; k++) begin
         wprod    = wv[k[1]] * wu[k[0]];
         w1_in[k] = (dep_src[k] != '0) ? wprod[WGT_W-1:0] : '0;
      end
   end

   always_comb begin
      sw3_in = '0;
      si3_in = '0;
      sz3_in = '0;
      for (int k = 0; k < NEIGH; k++) begin
         sw3_in = sw3_in + w2_ff[k];
         si3_in = si3_in + pi2_ff[k];
         sz3_in = sz3_in + pz2_ff[k];
      end
   end

   assign half3 = sw3_ff >> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_bus.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < NEIGH; k++) begin
            w1_ff[k]  <= w1_in[k];
            i1_ff[k]  <= int_src[k];
            z1_ff[k]  <= dep_src[k];
            w2_ff[k]  <= w1_ff[k];
            pi2_ff[k] <= PI_W'(w1_ff[k]) * PI_W'(i1_ff[k]);
            pz2_ff[k] <= PZ_W'(w1_ff[k]) * PZ_W'(z1_ff[k]);
         end
         sw3_ff  <= sw3_in;
         si3_ff  <= si3_in;
         sz3_ff  <= sz3_in;
         nz4_ff  <= (sw3_ff != '0);
         dvs4_ff <= sw3_ff;
         num4_ff[LANE_INT] <= (NUM_W'(si3_ff) << INT_FRAC_SHIFT) + NUM_W'(half3);
         num4_ff[LANE_DEP] <= NUM_W'(sz3_ff) + NUM_W'(half3);
      end
   end

   assign div_in_ctl.valid = v4_ff;
   assign div_in_ctl.nz    = nz4_ff;

   dmbs_div_pipe u_div (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_ctl     (div_in_ctl),
      .in_divisor (dvs4_ff),
      .in_num     (num4_ff),
      .out_ctl    (div_out_ctl),
      .out_quo    (div_quo)
   );

   assign rsp_bus.valid     = div_out_ctl.valid;
   assign rsp_bus.valid_res = div_out_ctl.nz;
   assign rsp_bus.int_out   = div_out_ctl.nz ? div_quo[LANE_INT][INT_OUT_W-1:0] : '0;
   assign rsp_bus.dep_out   = div_out_ctl.nz ?
                              DEP_OUT_W'(div_quo[LANE_DEP][QZ_W-1:0]) : '0;

`ifndef SYNTHESIS
   a_int_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.valid_res |-> rsp_bus.int_out <= INT_OUT_MAX)
      else $error("interpolated intensity above full scale");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_bus.valid && !rsp_bus.ready)
      else $error("request held off without a blocked response");

   a_entry: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> v1_ff)
      else $error("accepted beat missing from first stage");
`endif

endmodule
